// ===== rtl/dac_pkg.sv =====
package dac_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int STA_W       = 48;
    localparam int HASH_W      = 32;
    localparam int OUT_CNT_W   = 9;
    localparam int STA_BYTES   = STA_W / 8;
    localparam int BYTE_CNT_W  = $clog2(STA_BYTES);

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    typedef struct packed {
        logic              vld;
        logic [HASH_W-1:0] value;
    } dac_hash_t;

    typedef struct packed {
        logic                 vld;
        logic [HASH_W-1:0]    hash;
        logic                 is_new;
        logic                 dropped;
        logic [OUT_CNT_W-1:0] count;
    } dac_result_t;

endpackage

// ===== rtl/dac_hash.sv =====
module dac_hash
    import dac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [STA_W-1:0] station_address,
    output dac_hash_t        hash_out
);

    logic [STA_W-1:0]      data_reg, data_next;
    logic [HASH_W-1:0]     h_reg, h_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  vld_reg, vld_next;
    logic [HASH_W-1:0]     mix;

    // one byte per cycle, most significant byte first
    always_comb
    begin
        mix       = h_reg ^ {{(HASH_W-8){1'b0}}, data_reg[STA_W-1 -: 8]};
        data_next = data_reg;
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        vld_next  = 1'b0;
        if (start)
        begin
            data_next = station_address;
            h_next    = FNV_BASIS;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            h_next    = mix * FNV_PRIME;
            data_next = {data_reg[STA_W-9:0], 8'h00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == BYTE_CNT_W'(STA_BYTES - 1))
            begin
                run_next = 1'b0;
                vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            vld_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        h_reg    <= h_next;
    end

    // zero is reserved, map it to one
    assign hash_out.vld   = vld_reg;
    assign hash_out.value = (h_reg == '0) ? HASH_W'(1) : h_reg;

endmodule

// ===== rtl/dac_table.sv =====
module dac_table
    import dac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dac_hash_t   hash_in,
    output dac_result_t result
);

    logic [HASH_W-1:0] seen_mem [TABLE_DEPTH];
    logic [HASH_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;

    logic              scan_reg, scan_next;
    logic              rvld_reg, rvld_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [HASH_W-1:0] key_reg, key_next;
    dac_result_t       res_reg, res_next;
    logic [CNT_W+OUT_CNT_W-1:0] count_wide;

    assign rd_addr = issue_reg[ADDR_W-1:0];

    // issue one read per cycle, compare each in the cycle after its read
    always_comb
    begin
        scan_next  = scan_reg;
        rvld_next  = 1'b0;
        issue_next = issue_reg;
        count_next = count_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        res_next.vld = 1'b0;
        we         = 1'b0;
        count_wide = '0;
        if (hash_in.vld)
        begin
            scan_next  = 1'b1;
            issue_next = '0;
            key_next   = hash_in.value;
        end
        else if (scan_reg)
        begin
            if (issue_reg != count_reg)
            begin
                rvld_next  = 1'b1;
                issue_next = issue_reg + 1'b1;
            end
            if (rvld_reg && rd_data_reg == key_reg)
            begin
                scan_next       = 1'b0;
                rvld_next       = 1'b0;
                res_next.vld    = 1'b1;
                res_next.is_new = 1'b0;
                res_next.dropped = 1'b0;
            end
            else if (!rvld_reg && issue_reg == count_reg)
            begin
                scan_next    = 1'b0;
                res_next.vld = 1'b1;
                if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    we               = 1'b1;
                    count_next       = count_reg + 1'b1;
                    res_next.is_new  = 1'b1;
                    res_next.dropped = 1'b0;
                end
                else
                begin
                    res_next.is_new  = 1'b0;
                    res_next.dropped = 1'b1;
                end
            end
            res_next.hash  = key_reg;
            count_wide     = {{OUT_CNT_W{1'b0}}, count_next};
            res_next.count = count_wide[OUT_CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            seen_mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        rd_data_reg <= seen_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= 1'b0;
            rvld_reg   <= 1'b0;
            issue_reg  <= '0;
            count_reg  <= '0;
            res_reg    <= '0;
        end
        else
        begin
            scan_reg   <= scan_next;
            rvld_reg   <= rvld_next;
            issue_reg  <= issue_next;
            count_reg  <= count_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
    end

    assign result = res_reg;

endmodule

// ===== rtl/distinct_address_counter_core.sv =====
// Channel   Ports                                          Transfer
// --------  ---------------------------------------------  ------------------------
// command   start, busy, station_address                   start && !busy at clk
// result    done, address_hash, is_new, dropped_full,      done high, one cycle
//           distinct_count
//
// A new or dropped address is compared against all stored hashes, up to 256 with
// a full table, while a hit at entry j ends the search there. The hash folds in one
// byte per 32-bit multiply; the search then reads one stored entry per cycle.
// rst_n clears the entry count at once; the hash memory is never cleared, only
// entries below the count are read. Results cannot stall.
module distinct_address_counter_core
    import dac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [STA_W-1:0]     station_address,
    output logic                 done,
    output logic [HASH_W-1:0]    address_hash,
    output logic                 is_new,
    output logic                 dropped_full,
    output logic [OUT_CNT_W-1:0] distinct_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        accept;
    dac_hash_t   hash_bus;
    dac_result_t result;

    // accept a command only while nothing is in flight
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                // advance once the last byte is folded in
                if (hash_bus.vld)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // hold busy through the result cycle, then drop back
                if (result.vld)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    dac_hash u_hash (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept),
        .station_address (station_address),
        .hash_out        (hash_bus)
    );

    dac_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .hash_in (hash_bus),
        .result  (result)
    );

    // the table's result register is the output register
    assign done           = result.vld;
    assign address_hash   = result.hash;
    assign is_new         = result.is_new;
    assign dropped_full   = result.dropped;
    assign distinct_count = result.count;

endmodule

// ===== rtl/dac_checker.sv =====
module dac_checker
    import dac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 done,
    input  logic [HASH_W-1:0]    address_hash,
    input  logic                 is_new,
    input  logic                 dropped_full,
    input  logic [OUT_CNT_W-1:0] distinct_count
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted command");

    a_hash_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> address_hash != '0)
        else $error("zero hash delivered");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_new && dropped_full))
        else $error("new and dropped both set");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result delivered while idle");

    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_new |-> distinct_count != '0)
        else $error("new entry stored but count is zero");

endmodule

bind distinct_address_counter_core dac_checker u_dac_checker (.*);

// ===== bench/tb_distinct_address_counter_core.sv =====
module tb_distinct_address_counter_core;
    import dac_pkg::*;

    // Worst case per address: a full-table search plus the longest sender gap and
    // the handshake, for about 560 addresses, then taken roughly four times over.
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_ADDRS = 525;
    localparam int SETTLE_CYCLES = 300;
    localparam int REPORT_MAX = 10;

    // One predicted outcome for one station address.
    typedef struct {
        logic [HASH_W-1:0]    hash;
        logic                 is_new;
        logic                 dropped;
        logic [OUT_CNT_W-1:0] count;
    } address_verdict_t;

    // Tracks the set of distinct hashes and matches each done against the
    // oldest outstanding verdict.
    class distinct_set_tracker;
        logic [HASH_W-1:0] stored[TABLE_DEPTH];
        int unsigned held;
        address_verdict_t pending_verdicts[$];
        int unsigned mismatches;
        int unsigned n_new;
        int unsigned n_present;
        int unsigned n_dropped;

        function new();
            held = 0;
            mismatches = 0;
            n_new = 0;
            n_present = 0;
            n_dropped = 0;
        endfunction

        function automatic logic [HASH_W-1:0] fold_address(logic [STA_W-1:0] addr);
            logic [HASH_W-1:0] h;
            int b;
            h = FNV_BASIS;
            for (b = STA_BYTES - 1; b >= 0; b--)
            begin
                h = h ^ {24'd0, addr[8*b +: 8]};
                h = h * FNV_PRIME;
            end
            if (h == '0)
                h = HASH_W'(1);
            return h;
        endfunction

        function void note_address(logic [STA_W-1:0] addr);
            address_verdict_t v;
            bit hit;
            int unsigned i;
            hit = 0;
            v.hash = fold_address(addr);
            for (i = 0; i < held; i++)
                if (stored[i] == v.hash)
                    hit = 1;
            v.is_new = 0;
            v.dropped = 0;
            if (hit)
                n_present++;
            else if (held < TABLE_DEPTH)
            begin
                stored[held] = v.hash;
                held++;
                v.is_new = 1;
                n_new++;
            end
            else
            begin
                v.dropped = 1;
                n_dropped++;
            end
            v.count = held[OUT_CNT_W-1:0];
            pending_verdicts.push_back(v);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        function void check_result(logic [HASH_W-1:0] hash, logic new_flag,
                                   logic drop_flag, logic [OUT_CNT_W-1:0] cnt);
            address_verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                flag($sformatf("unexpected done: hash %08h new %b dropped %b count %0d",
                               hash, new_flag, drop_flag, cnt));
                return;
            end
            v = pending_verdicts.pop_front();
            if (hash !== v.hash)
                flag($sformatf("address_hash exp %08h got %08h", v.hash, hash));
            if (new_flag !== v.is_new)
                flag($sformatf("is_new exp %b got %b (hash %08h)", v.is_new, new_flag, v.hash));
            if (drop_flag !== v.dropped)
                flag($sformatf("dropped_full exp %b got %b (hash %08h)",
                               v.dropped, drop_flag, v.hash));
            if (cnt !== v.count)
                flag($sformatf("distinct_count exp %0d got %0d (hash %08h)",
                               v.count, cnt, v.hash));
        endfunction

        function int unsigned outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [STA_W-1:0]     station_address = '0;
    logic                 busy;
    logic                 done;
    logic [HASH_W-1:0]    address_hash;
    logic                 is_new;
    logic                 dropped_full;
    logic [OUT_CNT_W-1:0] distinct_count;

    distinct_set_tracker tracker;
    logic [STA_W-1:0] issued_addrs[$];

    distinct_address_counter_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .station_address(station_address),
        .done           (done),
        .address_hash   (address_hash),
        .is_new         (is_new),
        .dropped_full   (dropped_full),
        .distinct_count (distinct_count)
    );

    // 20-unit clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watch both channels at each rising edge. Values read here are the ones
    // the block itself saw at the edge, since every driver updates through
    // nonblocking assignments. Note the accepted address before checking a
    // done so that a same-edge pair keeps its order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_address(station_address);
            if (done)
                tracker.check_result(address_hash, is_new, dropped_full, distinct_count);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 LIMIT_CYCLES, tracker.outstanding());
        $display("Mismatches found");
        $finish;
    end

    // Present one address and hold it until the block takes the transfer.
    task automatic send_address(logic [STA_W-1:0] addr);
        start <= 1'b1;
        station_address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start for a random gap in about 27 of 100 transfers; now and then
    // make the gap long enough to land deep inside a table search.
    task automatic maybe_idle();
        int gap;
        if ($urandom_range(0, 99) < 27)
        begin
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(10, 120);
            else
                gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // Pick the next random address: mostly fresh ones so the table fills and
    // then overflows, with repeats and one-byte variants of earlier addresses.
    function automatic logic [STA_W-1:0] next_address();
        logic [STA_W-1:0] a;
        int roll;
        int pos;
        roll = $urandom_range(0, 99);
        if (issued_addrs.size() != 0 && roll < 25)
            return issued_addrs[$urandom_range(0, issued_addrs.size() - 1)];
        if (issued_addrs.size() != 0 && roll < 35)
        begin
            a = issued_addrs[$urandom_range(0, issued_addrs.size() - 1)];
            pos = $urandom_range(0, STA_BYTES - 1);
            a[8*pos +: 8] = 8'($urandom_range(0, 255));
        end
        else
        begin
            a[47:32] = 16'($urandom_range(0, 16'hFFFF));
            a[31:0] = $urandom();
        end
        issued_addrs.push_back(a);
        return a;
    endfunction

    initial
    begin
        logic [STA_W-1:0] directed_addrs[$];
        int k;
        tracker = new();

        // Hold reset low from time zero, then release it on an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, single-bit and byte patterns, and
        // repeats of addresses already held (hash present, nothing changes).
        directed_addrs = '{
            48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001,
            48'h8000_0000_0000, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
            48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0102_0304_0506,
            48'h0605_0403_0201, 48'hFF00_0000_0000, 48'h0000_0000_00FF,
            48'h0011_2233_4455, 48'h0011_2233_4456, 48'h0102_0304_0506,
            48'hDEAD_BEEF_CAFE, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000
        };
        foreach (directed_addrs[i])
        begin
            maybe_idle();
            send_address(directed_addrs[i]);
            issued_addrs.push_back(directed_addrs[i]);
        end
        drain_results();

        // Random part. Keep one long stretch free of idling, and drain the
        // pipeline twice on the way so the sender restarts from an idle block.
        for (k = 0; k < RANDOM_ADDRS; k++)
        begin
            if (k == 100 || k == 400)
                drain_results();
            else if (k < 150 || k >= 300)
                maybe_idle();
            send_address(next_address());
        end

        // Wait out every outstanding result, then a settling margin.
        start <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.outstanding() != 0)
            tracker.flag($sformatf("%0d results never arrived", tracker.outstanding()));

        $display("Covered %0d addresses: %0d newly stored, %0d already held, %0d refused full",
                 tracker.n_new + tracker.n_present + tracker.n_dropped,
                 tracker.n_new, tracker.n_present, tracker.n_dropped);
        $display("Table reached %0d of %0d entries; %0d mismatching fields",
                 tracker.held, TABLE_DEPTH, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
